// ----- rtl/bkst_pkg.sv -----
`timescale 1ns / 1ps

package bkst_pkg;

    // Capacity of the set and the number of key bits that take part.
    localparam int MAX_ENTRIES = 32;
    localparam int KEY_BITS    = 64;

    // Fixed widths of the transfer fields.
    localparam int KEY_FIELD_W = 64;
    localparam int COUNT_OUT_W = 6;

    // Internal widths: an entry index, and a count that can reach the capacity.
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // Operation codes carried by an input item.
    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [KEY_FIELD_W-1:0] key;
    } t_in_item;

    typedef struct packed {
        logic                   was_member;
        logic [COUNT_OUT_W-1:0] entry_count;
        logic                   is_full;
        logic                   is_empty;
        logic                   dropped;
    } t_out_item;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic shift;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_kind kind;
        logic  hit;
        logic  pipe_idle;
        logic  out_free;
    } t_dp_status;

endpackage

// ----- rtl/bkst_ctrl.sv -----
`timescale 1ns / 1ps

module bkst_ctrl
    import bkst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_kind      i_in_kind,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_in_kind == KIND_CLEAR) ? ST_FINISH : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                o_cmd.scan = 1'b1;
                if (i_status.hit) begin
                    n_state = (i_status.kind == KIND_DELETE) ? ST_SHIFT : ST_FINISH;
                end else if (i_status.pipe_idle) begin
                    n_state = ST_FINISH;
                end
            end
            ST_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_status.pipe_idle) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/bkst_dp.sv -----
`timescale 1ns / 1ps

module bkst_dp
    import bkst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_in_data,
    input  t_dp_cmd    i_cmd,
    input  logic       i_out_stall,
    output t_dp_status o_status,
    output logic       o_out_valid,
    output t_out_item  o_out_data
);

    // Key store: one write and one registered read per cycle.
    logic [KEY_BITS-1:0] mem [MAX_ENTRIES];
    logic [KEY_BITS-1:0] r_rd_data;

    t_kind               r_kind;
    logic [KEY_BITS-1:0] r_key;
    logic                r_member;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic                r_cmp_vld;
    logic                r_out_vld;
    t_out_item           r_out;

    logic                issue;
    logic                hit;
    logic                full_now;
    logic                add_key;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [KEY_BITS-1:0] wr_data;
    logic [CNT_W-1:0]    n_count;
    t_out_item           n_out;

    // Scan pipeline: a read is issued at r_idx, compared or moved in the next cycle.
    assign issue    = (r_idx < r_count);
    assign hit      = r_cmp_vld && (r_rd_data == r_key);
    assign full_now = (r_count == CNT_W'(MAX_ENTRIES));
    assign add_key  = (r_kind == KIND_INSERT) && !r_member && !full_now;

    assign o_status.kind      = r_kind;
    assign o_status.hit       = hit;
    assign o_status.pipe_idle = !issue && !r_cmp_vld;
    assign o_status.out_free  = !r_out_vld || !i_out_stall;

    // Memory write: compaction moves during a delete, the append at the end of an insert.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cmp_idx - 1'b1;
        wr_data = r_rd_data;
        if (i_cmd.shift && r_cmp_vld) begin
            wr_en = 1'b1;
        end else if (i_cmd.finish && add_key) begin
            wr_en   = 1'b1;
            wr_addr = r_count[IDX_W-1:0];
            wr_data = r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[r_idx[IDX_W-1:0]];
    end

    // New count and the result item.
    always_comb begin
        n_count = r_count;
        case (r_kind)
            KIND_CLEAR: begin
                n_count = '0;
            end
            KIND_INSERT: begin
                if (add_key) begin
                    n_count = r_count + 1'b1;
                end
            end
            KIND_DELETE: begin
                if (r_member) begin
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_out.was_member  = r_member;
        n_out.entry_count = COUNT_OUT_W'(n_count);
        n_out.is_full     = (n_count == CNT_W'(MAX_ENTRIES));
        n_out.is_empty    = (n_count == '0);
        n_out.dropped     = (r_kind == KIND_INSERT) && !r_member && full_now;
    end

    // Operation registers and scan control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (i_cmd.load) begin
                r_idx     <= '0;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan && hit) begin
                // Compaction starts with the entry after the match.
                r_idx     <= CNT_W'(r_cmp_idx) + 1'b1;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan || i_cmd.shift) begin
                r_idx     <= r_idx + CNT_W'(issue);
                r_cmp_vld <= issue;
            end
            if (i_cmd.finish) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_in_data.kind;
            r_key    <= i_in_data.key[KEY_BITS-1:0];
            r_member <= 1'b0;
        end else if (i_cmd.scan && hit) begin
            r_member <= 1'b1;
        end
        if ((i_cmd.scan || i_cmd.shift) && issue) begin
            r_cmp_idx <= r_idx[IDX_W-1:0];
        end
    end

    // Output register: holds a result until its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/bounded_key_set_table_core.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Payload
// in        input      i_in_valid / o_in_stall  i_in_data  (t_in_item: kind, key)
// out       output     o_out_valid / i_out_stall o_out_data (t_out_item)
//
// A clear goes straight to the result; insert and query search the held entries,
// and a delete that finds its key also compacts the entries after it. Search
// and compaction walk one entry a cycle through the single read port of the key
// store. Reset empties the set at once; the key store needs no clearing pass.
// A finished result waits in the output register while the next item is taken;
// an item finishing while that register is still stalled waits for it.

module bounded_key_set_table_core
    import bkst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequencing of search, compaction and result.
    bkst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_kind  (i_in_data.kind),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Key store, count and output register.
    bkst_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
